// ===== design/rlqt_pkg.sv =====
// ----------------------------------------------------------------------------
// rlqt_pkg: record lock queue table shared definitions
// Sizes, status and operation codes and the sequencer state type.
// ----------------------------------------------------------------------------
package rlqt_pkg;

  localparam int ENTRIES    = 64;
  localparam int REQUESTERS = 64;

  localparam int EW = $clog2(ENTRIES);
  localparam int RW = $clog2(REQUESTERS);

  localparam int OP_W     = 1;
  localparam int TABLE_W  = 10;
  localparam int KEY_W    = 64;
  localparam int REQ_W    = 6;
  localparam int STATUS_W = 3;

  // link value that marks the end of a waiter queue
  localparam logic [RW:0] NO_WAITER = (RW+1)'(REQUESTERS);

  typedef enum logic [OP_W-1:0] {
    OP_ACQUIRE = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED    = 3'd0,
    ST_QUEUED     = 3'd1,
    ST_RELEASED   = 3'd2,
    ST_NO_SPACE   = 3'd3,
    ST_NOT_HOLDER = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_LOOKUP,
    S_EXEC,
    S_LINK,
    S_OUT
  } state_t;

endpackage

// ===== design/rlqt_ram.sv =====
// ----------------------------------------------------------------------------
// rlqt_ram: generic single write port memory
// One write and one read address per cycle, registered read data.
// ----------------------------------------------------------------------------
module rlqt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/record_lock_queue_table_core.sv =====
// ----------------------------------------------------------------------------
// record_lock_queue_table_core: exclusive record lock manager
// Lock table of (table id, record key) pairs with a FIFO waiter queue each.
// ----------------------------------------------------------------------------
// An acquire or release request is taken only while the block is idle and
// answered with exactly one result. The lock table lives in memory and is
// searched one entry per cycle by a single shared compare unit, which stops
// at the matching entry; the search sets the latency. Each request then
// passes through the lookup, exec and output states, and an acquire that
// joins a waiter queue also through a link state; the result may wait on
// out_stall in the output state.
// The next request may be taken while the previous result is still held in
// the output register.
module record_lock_queue_table_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [rlqt_pkg::OP_W-1:0]      in_operation,
  input  logic [rlqt_pkg::TABLE_W-1:0]   in_table_id,
  input  logic signed [rlqt_pkg::KEY_W-1:0] in_record_key,
  input  logic [rlqt_pkg::REQ_W-1:0]     in_requester,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rlqt_pkg::STATUS_W-1:0]  out_status,
  output logic                           out_handoff_valid,
  output logic [rlqt_pkg::REQ_W-1:0]     out_granted_requester
);

  localparam int EW   = rlqt_pkg::EW;
  localparam int RW   = rlqt_pkg::RW;
  localparam int TK_W = rlqt_pkg::TABLE_W + rlqt_pkg::KEY_W;
  localparam logic [EW-1:0] LAST_IDX = EW'(rlqt_pkg::ENTRIES - 1);

  rlqt_pkg::state_t state_r, state_nxt;

  // request
  logic [rlqt_pkg::OP_W-1:0]    op_r;
  logic [rlqt_pkg::TABLE_W-1:0] tab_r;
  logic [rlqt_pkg::KEY_W-1:0]   key_r;
  logic [rlqt_pkg::REQ_W-1:0]   req_r;
  logic [RW-1:0]                req_idx;
  logic                         req_in_range;

  // flop state
  logic [rlqt_pkg::ENTRIES-1:0]    entry_valid_r;
  logic [rlqt_pkg::REQUESTERS-1:0] req_busy_r;

  // scan
  logic [EW-1:0] scan_addr_r;
  logic          scan_issue_r;
  logic [EW-1:0] cmp_idx_r;
  logic          cmp_vld_r;
  logic [EW-1:0] tgt_idx_r;
  logic          hit_r;
  logic          free_found_r;
  logic          cmp_match;
  logic          cmp_free;
  logic          scan_done;

  // memories
  logic          tk_we;
  logic [TK_W-1:0] tk_rd;
  logic          q_we;
  logic [2*RW-1:0] q_wdata;
  logic [2*RW-1:0] q_rd;
  logic [RW-1:0] head_rd;
  logic [RW-1:0] tail_rd;
  logic          wn_we;
  logic [RW-1:0] wn_waddr;
  logic [RW:0]   wn_wdata;
  logic [RW:0]   wn_rd;

  // exec decisions
  logic          do_link;
  logic          busy_set;
  logic          busy_clr;
  logic          valid_set;
  logic          valid_clr;
  logic [RW-1:0] link_tail_r;
  rlqt_pkg::status_t res_status;
  logic          res_hv;
  logic [RW-1:0] res_gr;
  logic [rlqt_pkg::STATUS_W-1:0] res_status_r;
  logic          res_hv_r;
  logic [rlqt_pkg::REQ_W-1:0] res_gr_r;

  // output register
  logic                          out_valid_r;
  logic [rlqt_pkg::STATUS_W-1:0] out_status_r;
  logic                          out_hv_r;
  logic [rlqt_pkg::REQ_W-1:0]    out_gr_r;
  logic                          out_load;

  assign req_idx      = RW'(req_r);
  assign req_in_range = int'(req_r) < rlqt_pkg::REQUESTERS;
  assign head_rd      = q_rd[2*RW-1:RW];
  assign tail_rd      = q_rd[RW-1:0];

  assign in_stall = (state_r != rlqt_pkg::S_IDLE);

  // ---------------------------------------------------------------- memories
  rlqt_ram #(.WIDTH(TK_W), .DEPTH(rlqt_pkg::ENTRIES)) u_tk_ram (
    .clk   (clk),
    .we    (tk_we),
    .waddr (tgt_idx_r),
    .wdata ({tab_r, key_r}),
    .raddr (scan_addr_r),
    .rdata (tk_rd)
  );

  // head and tail of each entry's waiter queue
  rlqt_ram #(.WIDTH(2*RW), .DEPTH(rlqt_pkg::ENTRIES)) u_q_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (tgt_idx_r),
    .wdata (q_wdata),
    .raddr (tgt_idx_r),
    .rdata (q_rd)
  );

  rlqt_ram #(.WIDTH(RW+1), .DEPTH(rlqt_pkg::REQUESTERS)) u_wn_ram (
    .clk   (clk),
    .we    (wn_we),
    .waddr (wn_waddr),
    .wdata (wn_wdata),
    .raddr (req_idx),
    .rdata (wn_rd)
  );

  // ---------------------------------------------------------------- compare
  assign cmp_match = cmp_vld_r && entry_valid_r[cmp_idx_r] && (tk_rd == {tab_r, key_r});
  assign cmp_free  = cmp_vld_r && !entry_valid_r[cmp_idx_r];
  assign scan_done = cmp_match || (cmp_vld_r && (cmp_idx_r == LAST_IDX));

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rlqt_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = rlqt_pkg::S_SCAN;
        end
      end
      rlqt_pkg::S_SCAN: begin
        if (scan_done) begin
          state_nxt = rlqt_pkg::S_LOOKUP;
        end
      end
      rlqt_pkg::S_LOOKUP: state_nxt = rlqt_pkg::S_EXEC;
      rlqt_pkg::S_EXEC: begin
        if (do_link) begin
          state_nxt = rlqt_pkg::S_LINK;
        end else begin
          state_nxt = rlqt_pkg::S_OUT;
        end
      end
      rlqt_pkg::S_LINK: state_nxt = rlqt_pkg::S_OUT;
      rlqt_pkg::S_OUT: begin
        if (out_load) begin
          state_nxt = rlqt_pkg::S_IDLE;
        end
      end
      default: state_nxt = rlqt_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- outputs
  always_comb begin
    tk_we      = 1'b0;
    q_we       = 1'b0;
    q_wdata    = q_rd;
    wn_we      = 1'b0;
    wn_waddr   = req_idx;
    wn_wdata   = rlqt_pkg::NO_WAITER;
    do_link    = 1'b0;
    busy_set   = 1'b0;
    busy_clr   = 1'b0;
    valid_set  = 1'b0;
    valid_clr  = 1'b0;
    res_status = rlqt_pkg::ST_NO_SPACE;
    res_hv     = 1'b0;
    res_gr     = '0;
    out_load   = 1'b0;
    case (state_r)
      rlqt_pkg::S_EXEC: begin
        if (op_r == rlqt_pkg::OP_ACQUIRE) begin
          if (!req_in_range || req_busy_r[req_idx]) begin
            res_status = rlqt_pkg::ST_NO_SPACE;
          end else if (hit_r) begin
            q_we       = 1'b1;
            q_wdata    = {head_rd, req_idx};
            wn_we      = 1'b1;
            busy_set   = 1'b1;
            do_link    = 1'b1;
            res_status = rlqt_pkg::ST_QUEUED;
          end else if (free_found_r) begin
            tk_we      = 1'b1;
            q_we       = 1'b1;
            q_wdata    = {req_idx, req_idx};
            wn_we      = 1'b1;
            busy_set   = 1'b1;
            valid_set  = 1'b1;
            res_status = rlqt_pkg::ST_GRANTED;
          end else begin
            res_status = rlqt_pkg::ST_NO_SPACE;
          end
        end else begin
          if (!hit_r || !req_in_range || (head_rd != req_idx)) begin
            res_status = rlqt_pkg::ST_NOT_HOLDER;
          end else begin
            wn_we      = 1'b1;
            busy_clr   = 1'b1;
            res_status = rlqt_pkg::ST_RELEASED;
            if (int'(wn_rd) < rlqt_pkg::REQUESTERS) begin
              q_we    = 1'b1;
              q_wdata = {wn_rd[RW-1:0], tail_rd};
              res_hv  = 1'b1;
              res_gr  = wn_rd[RW-1:0];
            end else begin
              valid_clr = 1'b1;
            end
          end
        end
      end
      rlqt_pkg::S_LINK: begin
        // old tail now points at the new waiter
        wn_we    = 1'b1;
        wn_waddr = link_tail_r;
        wn_wdata = {1'b0, req_idx};
      end
      rlqt_pkg::S_OUT: begin
        out_load = !out_valid_r || !out_stall;
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= rlqt_pkg::S_IDLE;
      entry_valid_r <= '0;
      req_busy_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (valid_set) begin
        entry_valid_r[tgt_idx_r] <= 1'b1;
      end else if (valid_clr) begin
        entry_valid_r[tgt_idx_r] <= 1'b0;
      end
      if (busy_set) begin
        req_busy_r[req_idx] <= 1'b1;
      end else if (busy_clr) begin
        req_busy_r[req_idx] <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    if (state_r == rlqt_pkg::S_IDLE) begin
      op_r         <= in_operation;
      tab_r        <= in_table_id;
      key_r        <= in_record_key;
      req_r        <= in_requester;
      scan_addr_r  <= '0;
      scan_issue_r <= 1'b1;
      cmp_vld_r    <= 1'b0;
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
    end
    if (state_r == rlqt_pkg::S_SCAN) begin
      cmp_vld_r <= scan_issue_r && !scan_done;
      cmp_idx_r <= scan_addr_r;
      if (scan_issue_r) begin
        scan_addr_r <= scan_addr_r + 1'b1;
        if (scan_addr_r == LAST_IDX) begin
          scan_issue_r <= 1'b0;
        end
      end
      if (cmp_match) begin
        hit_r     <= 1'b1;
        tgt_idx_r <= cmp_idx_r;
      end else if (cmp_free && !free_found_r) begin
        free_found_r <= 1'b1;
        tgt_idx_r    <= cmp_idx_r;
      end
    end
    if (state_r == rlqt_pkg::S_EXEC) begin
      link_tail_r  <= tail_rd;
      res_status_r <= res_status;
      res_hv_r     <= res_hv;
      res_gr_r     <= rlqt_pkg::REQ_W'(res_gr);
    end
    if (out_load) begin
      out_status_r <= res_status_r;
      out_hv_r     <= res_hv_r;
      out_gr_r     <= res_gr_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_handoff_valid     = out_hv_r;
  assign out_granted_requester = out_gr_r;

  // ---------------------------------------------------------------- checks
  a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == rlqt_pkg::S_OUT))
    else $error("result appeared without a finished request");

  a_handoff_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_hv_r) |-> (out_status_r == rlqt_pkg::ST_RELEASED))
    else $error("handoff reported on a result that is not a release");

  a_busy_step: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(req_busy_r) <= $countones($past(req_busy_r)) + 1)
    else $error("more than one requester became busy at once");

  a_table_write_grant: assert property (@(posedge clk) disable iff (!rst_n)
    tk_we |-> (!hit_r && free_found_r && (op_r == rlqt_pkg::OP_ACQUIRE)))
    else $error("lock table written without a free entry on acquire");

  a_link_after_queue: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rlqt_pkg::S_LINK) |-> (hit_r && $past(busy_set)))
    else $error("queue link step without a queued acquire");

endmodule

// ===== verif/rlqt_lock_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rlqt_lock_checker: result checker for the record lock queue table
// Watches both channels, keeps its own copy of the lock table and waiter
// queues, predicts one result per request and compares it field by field.
// ----------------------------------------------------------------------------
module rlqt_lock_checker
  import rlqt_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [OP_W-1:0]           in_operation,
  input  logic [TABLE_W-1:0]        in_table_id,
  input  logic signed [KEY_W-1:0]   in_record_key,
  input  logic [REQ_W-1:0]          in_requester,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [STATUS_W-1:0]       out_status,
  input  logic                      out_handoff_valid,
  input  logic [REQ_W-1:0]          out_granted_requester,
  output int                        err_count,
  output int                        pending_count,
  output int                        checked_count,
  output int                        handoff_count
);

  typedef struct packed {
    status_t          status;
    logic             handoff;
    logic [REQ_W-1:0] granted;
  } lock_result_t;

  // lock table copy
  logic               lk_valid  [ENTRIES];
  logic [TABLE_W-1:0] lk_table  [ENTRIES];
  logic [KEY_W-1:0]   lk_key    [ENTRIES];
  logic [RW-1:0]      lk_holder [ENTRIES];
  logic [RW-1:0]      lk_last   [ENTRIES];
  // per-requester queue links
  logic [RW:0]        next_waiter [REQUESTERS];
  logic               req_active  [REQUESTERS];

  lock_result_t owed_q[$];

  function automatic int find_lock(logic [TABLE_W-1:0] tab, logic [KEY_W-1:0] key);
    for (int i = 0; i < ENTRIES; i++)
      if (lk_valid[i] && lk_table[i] == tab && lk_key[i] == key) return i;
    return -1;
  endfunction

  function automatic int find_unused();
    for (int i = 0; i < ENTRIES; i++)
      if (!lk_valid[i]) return i;
    return -1;
  endfunction

  function automatic lock_result_t apply_lock_request(op_t op, logic [TABLE_W-1:0] tab,
                                                      logic [KEY_W-1:0] key,
                                                      logic [REQ_W-1:0] req);
    lock_result_t res;
    int           hit;
    int           slot;
    logic [RW:0]  nxt;
    res.status  = ST_NOT_HOLDER;
    res.handoff = 1'b0;
    res.granted = '0;
    hit = find_lock(tab, key);
    if (op == OP_ACQUIRE) begin
      if (int'(req) >= REQUESTERS || req_active[req]) begin
        res.status = ST_NO_SPACE;
      end else if (hit >= 0) begin
        // append behind the current tail
        next_waiter[lk_last[hit]] = (RW+1)'(req);
        lk_last[hit]     = req;
        next_waiter[req] = NO_WAITER;
        req_active[req]  = 1'b1;
        res.status       = ST_QUEUED;
      end else begin
        slot = find_unused();
        if (slot < 0) begin
          res.status = ST_NO_SPACE;
        end else begin
          lk_valid[slot]   = 1'b1;
          lk_table[slot]   = tab;
          lk_key[slot]     = key;
          lk_holder[slot]  = req;
          lk_last[slot]    = req;
          next_waiter[req] = NO_WAITER;
          req_active[req]  = 1'b1;
          res.status       = ST_GRANTED;
        end
      end
    end else begin
      if (hit >= 0 && int'(req) < REQUESTERS && lk_holder[hit] == req) begin
        nxt = next_waiter[req];
        req_active[req]  = 1'b0;
        next_waiter[req] = NO_WAITER;
        if (int'(nxt) < REQUESTERS) begin
          lk_holder[hit] = nxt[RW-1:0];
          res.handoff    = 1'b1;
          res.granted    = nxt[RW-1:0];
        end else begin
          lk_valid[hit] = 1'b0;
        end
        res.status = ST_RELEASED;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    lock_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) lk_valid[i] = 1'b0;
      for (int r = 0; r < REQUESTERS; r++) req_active[r] = 1'b0;
      owed_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        owed_q.push_back(apply_lock_request(op_t'(in_operation), in_table_id,
                                            in_record_key, in_requester));
      end
      if (out_valid && !out_stall) begin
        if (owed_q.size() == 0) begin
          $display("%0t: result with nothing expected: status %0d handoff %0b granted %0d",
                   $time, out_status, out_handoff_valid, out_granted_requester);
          err_count++;
        end else begin
          want = owed_q.pop_front();
          checked_count++;
          if (out_handoff_valid === 1'b1) handoff_count++;
          if (out_status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, out_status);
            err_count++;
          end
          if (out_handoff_valid !== want.handoff) begin
            $display("%0t: handoff_valid mismatch: expected %0b, actual %0b",
                     $time, want.handoff, out_handoff_valid);
            err_count++;
          end
          if (out_granted_requester !== want.granted) begin
            $display("%0t: granted_requester mismatch: expected %0d, actual %0d",
                     $time, want.granted, out_granted_requester);
            err_count++;
          end
        end
      end
    end
    pending_count = owed_q.size();
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: record lock queue table testbench
// Directed lock and release sequences, a full-table pass and random lock
// traffic under several idle and back-pressure mixes; results are checked
// by rlqt_lock_checker.
// ----------------------------------------------------------------------------
module tb;
  import rlqt_pkg::*;

  localparam int POOL           = 64;
  localparam int HOT            = 8;
  localparam int PHASE_ITEMS    = 150;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [OP_W-1:0]         in_operation;
  logic [TABLE_W-1:0]      in_table_id;
  logic signed [KEY_W-1:0] in_record_key;
  logic [REQ_W-1:0]        in_requester;
  logic                    out_valid;
  logic                    out_stall;
  logic [STATUS_W-1:0]     out_status;
  logic                    out_handoff_valid;
  logic [REQ_W-1:0]        out_granted_requester;

  int errors;
  int pending;
  int checked;
  int handoffs;

  int idle_pct;
  int stall_pct;
  bit hold_off_req;
  int sent;

  // records used by the traffic; the first few are hot
  logic [TABLE_W-1:0] pool_tab [POOL];
  logic [KEY_W-1:0]   pool_key [POOL];

  // rough view of who holds or waits, used only to shape stimulus
  bit busy  [REQUESTERS];
  int owner [REQUESTERS];
  int stamp [REQUESTERS];
  int stamp_ctr;

  record_lock_queue_table_core i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_operation          (in_operation),
    .in_table_id           (in_table_id),
    .in_record_key         (in_record_key),
    .in_requester          (in_requester),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_status            (out_status),
    .out_handoff_valid     (out_handoff_valid),
    .out_granted_requester (out_granted_requester)
  );

  rlqt_lock_checker i_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_operation          (in_operation),
    .in_table_id           (in_table_id),
    .in_record_key         (in_record_key),
    .in_requester          (in_requester),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_status            (out_status),
    .out_handoff_valid     (out_handoff_valid),
    .out_granted_requester (out_granted_requester),
    .err_count             (errors),
    .pending_count         (pending),
    .checked_count         (checked),
    .handoff_count         (handoffs)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver: random stall, with one long hold-off on request
  initial begin
    int held;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        held = 0;
        while (held < HOLD_CYCLES) begin
          out_stall <= 1'b1;
          @(posedge clk);
          held++;
        end
        hold_off_req = 1'b0;
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    int stuck;
    stuck = 0;
    while (stuck < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck = 0;
      else stuck++;
    end
    $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // earliest arrival among the requesters on record k is the holder
  function automatic int holder_of(int k);
    int best;
    best = -1;
    for (int r = 0; r < REQUESTERS; r++)
      if (busy[r] && owner[r] == k && (best < 0 || stamp[r] < stamp[best])) best = r;
    return best;
  endfunction

  function automatic int pick_free();
    int start;
    start = $urandom_range(REQUESTERS-1);
    for (int i = 0; i < REQUESTERS; i++)
      if (!busy[(start+i) % REQUESTERS]) return (start+i) % REQUESTERS;
    return -1;
  endfunction

  function automatic int pick_busy();
    int start;
    start = $urandom_range(REQUESTERS-1);
    for (int i = 0; i < REQUESTERS; i++)
      if (busy[(start+i) % REQUESTERS]) return (start+i) % REQUESTERS;
    return -1;
  endfunction

  function automatic int pick_holder();
    int start;
    int r;
    start = $urandom_range(REQUESTERS-1);
    for (int i = 0; i < REQUESTERS; i++) begin
      r = (start+i) % REQUESTERS;
      if (busy[r] && holder_of(owner[r]) == r) return r;
    end
    return -1;
  endfunction

  task automatic put(op_t op, logic [TABLE_W-1:0] tab, logic [KEY_W-1:0] key,
                     logic [REQ_W-1:0] req);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_table_id   <= tab;
    in_record_key <= key;
    in_requester  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic request(op_t op, int k, logic [REQ_W-1:0] req);
    put(op, pool_tab[k], pool_key[k], req);
    if (op == OP_ACQUIRE) begin
      if (!busy[req]) begin
        busy[req]  = 1'b1;
        owner[req] = k;
        stamp[req] = stamp_ctr;
        stamp_ctr++;
      end
    end else if (holder_of(k) == int'(req)) begin
      busy[req] = 1'b0;
    end
  endtask

  task automatic release_all();
    int r;
    r = pick_holder();
    while (r >= 0) begin
      request(OP_RELEASE, owner[r], REQ_W'(r));
      r = pick_holder();
    end
  endtask

  task automatic random_request();
    int roll;
    int k;
    int r;
    roll = $urandom_range(99);
    k    = ($urandom_range(4) != 0) ? $urandom_range(HOT-1) : $urandom_range(POOL-1);
    r    = pick_free();
    if (roll < 45 && r >= 0) begin
      request(OP_ACQUIRE, k, REQ_W'(r));
    end else if (roll < 82 && pick_holder() >= 0) begin
      r = pick_holder();
      request(OP_RELEASE, owner[r], REQ_W'(r));
    end else begin
      // broken requests: wrong releaser, busy acquirer, unknown record
      r = pick_busy();
      case ($urandom_range(2))
        0: request(OP_RELEASE, k, REQ_W'($urandom_range(REQUESTERS-1)));
        1: begin
          if (r >= 0) put(OP_ACQUIRE, TABLE_W'($urandom_range(1023)),
                          {$urandom, $urandom}, REQ_W'(r));
          else request(OP_ACQUIRE, k, REQ_W'($urandom_range(REQUESTERS-1)));
        end
        default: put(OP_RELEASE, TABLE_W'($urandom_range(1023)), {$urandom, $urandom},
                     REQ_W'($urandom_range(REQUESTERS-1)));
      endcase
    end
  endtask

  initial begin
    int idle_mix  [4];
    int stall_mix [4];
    idle_mix  = '{0, 71, 0, 26};
    stall_mix = '{0, 0, 71, 26};
    idle_pct      = 0;
    stall_pct     = 0;
    hold_off_req  = 1'b0;
    sent          = 0;
    stamp_ctr     = 0;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_operation  <= OP_ACQUIRE;
    in_table_id   <= '0;
    in_record_key <= '0;
    in_requester  <= '0;
    for (int r = 0; r < REQUESTERS; r++) begin
      busy[r]  = 1'b0;
      owner[r] = -1;
      stamp[r] = 0;
    end
    for (int k = 0; k < POOL; k++) begin
      pool_tab[k] = TABLE_W'($urandom_range(1023));
      pool_key[k] = {$urandom, $urandom};
    end
    // extremes, and pairs that differ only in the key or only in the table
    pool_tab[0] = 10'd0;    pool_key[0] = 64'h8000_0000_0000_0000;
    pool_tab[1] = 10'd1023; pool_key[1] = 64'h7fff_ffff_ffff_ffff;
    pool_tab[2] = 10'd1023; pool_key[2] = 64'h7fff_ffff_ffff_fffe;
    pool_tab[3] = 10'd1022; pool_key[3] = 64'h7fff_ffff_ffff_ffff;
    pool_tab[4] = 10'd0;    pool_key[4] = 64'h0;
    pool_tab[5] = 10'd512;  pool_key[5] = 64'hffff_ffff_ffff_ffff;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // queue of three on one record, handed along in arrival order
    request(OP_ACQUIRE, 0, 6'd0);
    request(OP_ACQUIRE, 0, 6'd63);
    request(OP_ACQUIRE, 0, 6'd5);
    request(OP_ACQUIRE, 1, 6'd0);    // requester already busy
    request(OP_RELEASE, 0, 6'd5);    // waiter is not the holder
    request(OP_RELEASE, 4, 6'd1);    // record not locked
    request(OP_RELEASE, 0, 6'd0);
    request(OP_RELEASE, 0, 6'd63);
    request(OP_RELEASE, 0, 6'd5);    // last holder frees the entry
    request(OP_RELEASE, 0, 6'd5);
    request(OP_ACQUIRE, 1, 6'd1);
    request(OP_ACQUIRE, 2, 6'd2);
    request(OP_ACQUIRE, 3, 6'd3);
    request(OP_ACQUIRE, 1, 6'd4);
    request(OP_RELEASE, 2, 6'd1);    // holder of a neighboring record
    request(OP_RELEASE, 5, 6'd62);
    request(OP_ACQUIRE, 4, 6'd62);
    request(OP_ACQUIRE, 5, 6'd42);
    request(OP_RELEASE, 1, 6'd1);
    release_all();

    // every entry in use, then requests that search a full table
    for (int k = 0; k < POOL; k++) request(OP_ACQUIRE, k, REQ_W'(k));
    request(OP_ACQUIRE, 7, 6'd9);
    put(OP_ACQUIRE, 10'd777, 64'h0123_4567_89ab_cdef, 6'd33);
    put(OP_RELEASE, 10'd777, 64'h0123_4567_89ab_cdef, 6'd33);
    release_all();

    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_mix[p];
      stall_pct = stall_mix[p];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // long receiver hold-off while requests keep coming
        if (p == 0 && n == 40) hold_off_req = 1'b1;
        random_request();
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("run covered %0d requests and %0d checked results, %0d of them lock handoffs",
             sent, checked, handoffs);
    $display("including a full lock table, long waiter queues and a receiver hold-off");
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
